// File: src/lst_pkg.sv
package lst_pkg;
	localparam int NUM_OPS_DEF   = 64;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IDX_W  = 6;
	localparam int LAT_W  = 32;
	localparam int CNT_W  = 32;
	localparam int MEAN_W = 48;
	localparam int M2_W   = 64;
	localparam int TOT_W  = 64;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [LAT_W-1:0] lat;
	} lst_item_t;
endpackage

// File: src/lst_front.sv
module lst_front
	import lst_pkg::*;
#(
	parameter int NUM_OPS = NUM_OPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [IDX_W-1:0] op_index,
	input  logic [LAT_W-1:0] latency_us,
	output logic             q_valid,
	input  logic             q_ready,
	output lst_item_t        q_item
);
	// two-entry queue; items aimed beyond the table are dropped here
	lst_item_t  mem_q [QUEUE_DEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'(QUEUE_DEPTH));
	assign push = in_valid && in_ready && (32'(op_index) < NUM_OPS);
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= '{idx: op_index, lat: latency_us};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// File: src/lst_divider.sv
module lst_divider
	import lst_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [M2_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic            busy,
	output logic [M2_W-1:0] quotient
);
	// restoring divide, one quotient bit per cycle
	logic [M2_W-1:0]  quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic [6:0]       cnt_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;

	assign trial = {rem_q, quo_q[M2_W-1]};
	assign diff = trial - {1'b0, dvs_q};
	assign busy = (cnt_q != 7'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!diff[CNT_W]) begin
				rem_q <= diff[CNT_W-1:0];
				quo_q <= {quo_q[M2_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[CNT_W-1:0];
				quo_q <= {quo_q[M2_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= 7'd0;
		else if (start) cnt_q <= 7'(M2_W);
		else if (busy) cnt_q <= cnt_q - 7'd1;
	end
endmodule

// File: src/lst_back.sv
module lst_back
	import lst_pkg::*;
#(
	parameter int NUM_OPS   = NUM_OPS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  lst_item_t         q_item,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  row_index,
	output logic [CNT_W-1:0]  sample_count,
	output logic [LAT_W-1:0]  min_latency,
	output logic [LAT_W-1:0]  max_latency,
	output logic [MEAN_W-1:0] mean_latency,
	output logic [M2_W-1:0]   variance,
	output logic [TOT_W-1:0]  total_samples,
	output logic              saturated
);
	localparam int AW = (NUM_OPS > 1) ? $clog2(NUM_OPS) : 1;
	localparam int XW = LAT_W + FRAC_BITS;
	localparam int HW = (XW + 1) / 2;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_READ  = 10'b0000000010,
		S_DIFF  = 10'b0000000100,
		S_DIV1  = 10'b0000001000,
		S_STEP  = 10'b0000010000,
		S_MUL   = 10'b0000100000,
		S_ACC   = 10'b0001000000,
		S_DIV2  = 10'b0010000000,
		S_OUT   = 10'b0100000000,
		S_WAIT  = 10'b1000000000
	} st_t;

	st_t st_q;

	// row store; valid bits give the reset value of zero
	logic [CNT_W-1:0]  cnt_mem [NUM_OPS];
	logic [LAT_W-1:0]  min_mem [NUM_OPS];
	logic [LAT_W-1:0]  max_mem [NUM_OPS];
	logic [M2_W-1:0]   mean_mem [NUM_OPS];
	logic [M2_W-1:0]   m2_mem [NUM_OPS];
	logic [NUM_OPS-1:0] vld_q;

	logic [AW-1:0]    idx_q;
	logic [LAT_W-1:0] lat_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LAT_W-1:0] min_q, max_q;
	logic [M2_W-1:0]  mean_q, m2_q, nmean_q, dmag_q, e_q;
	logic             up_q, sat_q, vld_rd_q, relaunch_q;
	logic [1:0]       mul_ph_q;
	logic [2*M2_W-1:0] prod_q;
	logic [TOT_W-1:0] tot_q;

	logic [CNT_W-1:0] cnt_r;
	logic [LAT_W-1:0] min_r, max_r;
	logic [M2_W-1:0]  mean_r, m2_r;
	logic [M2_W-1:0]  x;
	logic             up_w;
	logic [M2_W-1:0]  dmag_w;

	logic [HW-1:0]     mul_a, mul_b;
	logic [2*HW-1:0]   mul_p;
	logic [2*M2_W-1:0] mul_ext, mul_sh;

	logic             dv_start, dv_busy;
	logic [M2_W-1:0]  dv_a, dv_q;
	logic [CNT_W-1:0] dv_b;

	assign x = M2_W'(lat_q) << FRAC_BITS;
	assign cnt_r  = vld_rd_q ? cnt_q  : '0;
	assign min_r  = vld_rd_q ? min_q  : '0;
	assign max_r  = vld_rd_q ? max_q  : '0;
	assign mean_r = vld_rd_q ? mean_q : '0;
	assign m2_r   = vld_rd_q ? m2_q   : '0;

	assign up_w = (x >= mean_r);
	assign dmag_w = up_w ? x - mean_r : mean_r - x;

	// product of two XW-bit magnitudes, one half-by-half partial product per cycle
	assign mul_a = mul_ph_q[1] ? dmag_q[2*HW-1:HW] : dmag_q[HW-1:0];
	assign mul_b = mul_ph_q[0] ? e_q[2*HW-1:HW] : e_q[HW-1:0];
	assign mul_p = mul_a * mul_b;
	assign mul_ext = (2*M2_W)'(mul_p);

	always_comb begin
		case (mul_ph_q)
			2'd0: mul_sh = mul_ext;
			2'd3: mul_sh = mul_ext << (2 * HW);
			default: mul_sh = mul_ext << HW;
		endcase
	end

	lst_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.dividend(dv_a), .divisor(dv_b), .busy(dv_busy), .quotient(dv_q)
	);

	assign q_ready = (st_q == S_IDLE);
	assign out_valid = (st_q == S_WAIT);

	logic [M2_W:0] inc_w, sum_w;
	assign inc_w = (prod_q[2*M2_W-1:M2_W+FRAC_BITS] != '0) ? {1'b1, {M2_W{1'b1}}}
		: {1'b0, prod_q[M2_W+FRAC_BITS-1:FRAC_BITS]};
	assign sum_w = inc_w + {1'b0, m2_r};

	always_comb begin
		dv_start = 1'b0;
		dv_a = dmag_w;
		dv_b = cnt_r + CNT_W'(1);
		case (st_q)
			S_DIFF: dv_start = 1'b1;
			S_DIV2: begin
				dv_start = relaunch_q && (cnt_r >= CNT_W'(2));
				dv_a = m2_r;
				dv_b = cnt_r - CNT_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: if (q_valid) begin
				idx_q <= AW'(q_item.idx);
				lat_q <= q_item.lat;
			end
			S_READ: begin
				cnt_q  <= cnt_mem[idx_q];
				min_q  <= min_mem[idx_q];
				max_q  <= max_mem[idx_q];
				mean_q <= mean_mem[idx_q];
				m2_q   <= m2_mem[idx_q];
				vld_rd_q <= vld_q[idx_q];
			end
			S_DIFF: begin
				sat_q <= (cnt_r == '1);
				up_q <= up_w;
				dmag_q <= dmag_w;
			end
			S_STEP: begin
				nmean_q <= up_q ? mean_r + dv_q : mean_r - dv_q;
				e_q <= up_q ? x - (mean_r + dv_q) : (mean_r - dv_q) - x;
				prod_q <= '0;
				mul_ph_q <= 2'd0;
			end
			S_MUL: begin
				prod_q <= prod_q + mul_sh;
				mul_ph_q <= mul_ph_q + 2'd1;
			end
			S_ACC: begin
				if (!sat_q) begin
					if (inc_w[M2_W] || sum_w[M2_W]) begin
						m2_q <= '1;
						sat_q <= 1'b1;
					end else m2_q <= sum_w[M2_W-1:0];
					cnt_q <= cnt_r + CNT_W'(1);
					mean_q <= nmean_q;
					min_q <= ((lat_q < min_r) || (min_r == '0)) ? lat_q : min_r;
					max_q <= (lat_q > max_r) ? lat_q : max_r;
					vld_rd_q <= 1'b1;
				end
			end
			S_DIV2: ;
			S_OUT: begin
				row_index <= IDX_W'(idx_q);
				sample_count <= cnt_r;
				min_latency <= min_r;
				max_latency <= max_r;
				mean_latency <= mean_r[MEAN_W-1:0];
				variance <= (cnt_r >= CNT_W'(2)) ? dv_q : '0;
				total_samples <= tot_q;
				saturated <= sat_q;
				cnt_mem[idx_q] <= cnt_r;
				min_mem[idx_q] <= min_r;
				max_mem[idx_q] <= max_r;
				mean_mem[idx_q] <= mean_r;
				m2_mem[idx_q] <= m2_r;
			end
			default: ;
		endcase
	end

	// The mean step divides in DIV1; the variance divide launches on entry to
	// DIV2, once ACC has written the updated count and m2, if the count is two or more.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			vld_q <= '0;
			tot_q <= '0;
			relaunch_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: if (q_valid) st_q <= S_READ;
				S_READ: st_q <= S_DIFF;
				S_DIFF: st_q <= S_DIV1;
				S_DIV1: if (!dv_busy) st_q <= S_STEP;
				S_STEP: st_q <= S_MUL;
				S_MUL: if (mul_ph_q == 2'd3) st_q <= S_ACC;
				S_ACC: begin
					if (!sat_q) tot_q <= tot_q + TOT_W'(1);
					relaunch_q <= 1'b1;
					st_q <= S_DIV2;
				end
				S_DIV2: begin
					relaunch_q <= 1'b0;
					if (!relaunch_q && !dv_busy) st_q <= S_OUT;
				end
				S_OUT: begin
					vld_q[idx_q] <= 1'b1;
					st_q <= S_WAIT;
				end
				S_WAIT: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: src/latency_stats_table_top.sv
// Latency statistics table.
// Input channel (in_valid/in_ready): op_index picks a row, latency_us gives
// one latency sample. Output channel (out_valid/out_ready): the updated row,
// its sample variance, the grand total and a saturation flag, one item per
// sample. Samples with op_index at or beyond NUM_OPS are dropped silently.
// A two-entry queue takes samples while the row engine works; once both
// entries hold items, in_ready drops until the engine takes one.
// From input accept to out_valid the row engine goes through read, difference,
// a 64-step restoring division for the mean step, a multiply from half-width
// partial products, accumulate, a second 64-step division for m2/(count-1)
// when the row ends up with two or more samples, and write back. The engine
// finishes one sample before it takes the next from the queue, so the shared
// bit-serial divider sets the throughput.
// Reset clears the queue, the per-row valid bits (rows then read as zero)
// and the grand total. A stalled receiver holds the result on the ports and
// halts the row engine; the queue then fills and in_ready drops.
module latency_stats_table_top
	import lst_pkg::*;
#(
	parameter int NUM_OPS   = NUM_OPS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [IDX_W-1:0]  op_index,
	input  logic [LAT_W-1:0]  latency_us,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  row_index,
	output logic [CNT_W-1:0]  sample_count,
	output logic [LAT_W-1:0]  min_latency,
	output logic [LAT_W-1:0]  max_latency,
	output logic [MEAN_W-1:0] mean_latency,
	output logic [M2_W-1:0]   variance,
	output logic [TOT_W-1:0]  total_samples,
	output logic              saturated
);
	logic      q_valid, q_ready;
	lst_item_t q_item;

	// front: accept and filter samples
	lst_front #(.NUM_OPS(NUM_OPS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op_index(op_index), .latency_us(latency_us),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	// back: row read-modify-write and variance
	lst_back #(.NUM_OPS(NUM_OPS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready),
		.row_index(row_index), .sample_count(sample_count),
		.min_latency(min_latency), .max_latency(max_latency),
		.mean_latency(mean_latency), .variance(variance),
		.total_samples(total_samples), .saturated(saturated)
	);
endmodule

// File: tb/testbench.sv
module testbench;
	import lst_pkg::*;

	// Pacing of the run
	localparam int NUM_RANDOM   = 1380;
	localparam int PAUSE_AT     = 700;   // sender waits for a drained block here
	localparam int STALL_AT     = 300;   // receiver holds off after this many results
	localparam int STALL_CYCLES = 1200;
	localparam int QUIET_TAIL   = 150;   // last results come with no idling
	localparam int WATCHDOG_MAX = 20000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic [IDX_W-1:0]  idx;
		logic [CNT_W-1:0]  cnt;
		logic [LAT_W-1:0]  min_lat;
		logic [LAT_W-1:0]  max_lat;
		logic [MEAN_W-1:0] mean;
		logic [M2_W-1:0]   var_q;
		logic [TOT_W-1:0]  total;
		logic              sat;
	} row_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [IDX_W-1:0] op_index = '0;
	logic [LAT_W-1:0] latency_us = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [IDX_W-1:0]  row_index;
	logic [CNT_W-1:0]  sample_count;
	logic [LAT_W-1:0]  min_latency;
	logic [LAT_W-1:0]  max_latency;
	logic [MEAN_W-1:0] mean_latency;
	logic [M2_W-1:0]   variance;
	logic [TOT_W-1:0]  total_samples;
	logic              saturated;

	latency_stats_table_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op_index(op_index), .latency_us(latency_us),
		.out_valid(out_valid), .out_ready(out_ready),
		.row_index(row_index), .sample_count(sample_count),
		.min_latency(min_latency), .max_latency(max_latency),
		.mean_latency(mean_latency), .variance(variance),
		.total_samples(total_samples), .saturated(saturated)
	);

	// Shadow copy of the statistics table
	logic [CNT_W-1:0]  stat_count [NUM_OPS_DEF];
	logic [LAT_W-1:0]  stat_min   [NUM_OPS_DEF];
	logic [LAT_W-1:0]  stat_max   [NUM_OPS_DEF];
	logic [63:0]       stat_mean  [NUM_OPS_DEF];
	logic [M2_W-1:0]   stat_m2    [NUM_OPS_DEF];
	logic [TOT_W-1:0]  stat_total;

	lst_item_t   pending_samples[$];
	row_report_t expected_rows[$];

	int n_sent = 0;
	int n_checked = 0;
	int n_clipped = 0;
	int n_errors = 0;
	int quiet_cycles = 0;
	bit in_taken = 1'b0;
	bit stall_done = 1'b0;
	bit stall_active = 1'b0;
	int stall_left = 0;
	int src_gap = 0;
	int sink_gap = 0;
	int total_items;

	// Welford update of one row; returns the row as the block should report it
	function automatic row_report_t update_row(lst_item_t s);
		row_report_t r;
		logic [5:0]   i;
		logic [31:0]  n;
		logic [63:0]  x, mu, dmag, stp, nmu, e, inc, m2;
		logic [127:0] prod;
		bit up, clip;
		i = s.idx;
		clip = 1'b0;
		if (stat_count[i] == '1) begin
			clip = 1'b1;
		end else begin
			n = stat_count[i] + 1;
			x = {16'd0, s.lat} << FRAC_BITS_DEF;
			mu = stat_mean[i];
			up = (x >= mu);
			dmag = up ? x - mu : mu - x;
			stp = dmag / {32'd0, n};
			nmu = up ? mu + stp : mu - stp;
			e = up ? x - nmu : nmu - x;
			prod = {64'd0, dmag} * {64'd0, e};
			if (prod[127:64+FRAC_BITS_DEF] != 0) begin
				clip = 1'b1;
				inc = '1;
			end else begin
				inc = prod[64+FRAC_BITS_DEF-1:FRAC_BITS_DEF];
			end
			m2 = stat_m2[i];
			if (inc > ~m2) begin
				m2 = '1;
				clip = 1'b1;
			end else begin
				m2 = m2 + inc;
			end
			stat_count[i] = n;
			stat_mean[i] = nmu;
			stat_m2[i] = m2;
			if (s.lat < stat_min[i] || stat_min[i] == 0)
				stat_min[i] = s.lat;
			if (s.lat > stat_max[i])
				stat_max[i] = s.lat;
			stat_total = stat_total + 1;
		end
		r.idx = i;
		r.cnt = stat_count[i];
		r.min_lat = stat_min[i];
		r.max_lat = stat_max[i];
		r.mean = stat_mean[i][MEAN_W-1:0];
		r.var_q = (stat_count[i] >= 2) ? stat_m2[i] / {32'd0, stat_count[i] - 32'd1} : '0;
		r.total = stat_total;
		r.sat = clip;
		return r;
	endfunction

	function automatic void add_sample(int idx, logic [31:0] lat);
		lst_item_t s;
		s.idx = idx[IDX_W-1:0];
		s.lat = lat;
		pending_samples = {pending_samples, s};
	endfunction

	// Random latency: mostly moderate, some full range, some extremes
	function automatic logic [31:0] pick_latency();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return $urandom_range(0, 5000);
		else if (sel < 8)
			return $urandom;
		else if (sel == 8)
			return 32'hFFFF_FFFF - $urandom_range(0, 3);
		else
			return $urandom_range(0, 2);
	endfunction

	// Clock: period 10
	initial begin
		forever #5 clk = ~clk;
	end

	// Stimulus: directed corners, then random samples
	initial begin
		int hot;
		for (int k = 0; k < NUM_OPS_DEF; k++) begin
			stat_count[k] = '0;
			stat_min[k] = '0;
			stat_max[k] = '0;
			stat_mean[k] = '0;
			stat_m2[k] = '0;
		end
		stat_total = '0;

		// zero latency leaves the minimum unset, a later one fills it
		add_sample(0, 32'd0);
		add_sample(0, 32'd0);
		add_sample(0, 32'd7);
		add_sample(0, 32'd3);
		add_sample(0, 32'd9);
		// first sample of a row, top index
		add_sample(63, 32'd1);
		add_sample(63, 32'hFFFF_FFFF);
		// swing between extremes so the squared deviation sum clips
		for (int k = 0; k < 6; k++)
			add_sample(1, (k % 2) ? 32'hFFFF_FFFF : 32'd0);
		add_sample(1, 32'd5);
		// mean moving down then up
		add_sample(2, 32'hFFFF_FFFF);
		add_sample(2, 32'd1);
		add_sample(2, 32'h8000_0000);
		add_sample(2, 32'h5555_5555);
		add_sample(2, 32'hAAAA_AAAA);
		add_sample(42, 32'h0000_0001);
		add_sample(21, 32'h7FFF_FFFF);
		add_sample(21, 32'h7FFF_FFFF);

		// random part: a few hot rows so counts and moments build up
		hot = $urandom_range(3, 60);
		for (int k = 0; k < NUM_RANDOM; k++) begin
			if ($urandom_range(0, 3) == 0)
				add_sample($urandom_range(0, NUM_OPS_DEF - 1), pick_latency());
			else
				add_sample(hot + $urandom_range(0, 3), pick_latency());
		end
		total_items = pending_samples.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (n_sent == total_items && expected_rows.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d samples over all 64 rows, %0d results checked, %0d clipped",
			n_sent, n_checked, n_clipped);
		$display("Covered min/max corners, m2 clipping, long output stall and drained pause");
		if (n_errors == 0 && expected_rows.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Input driver: change at the falling edge, hold an item until taken
	always @(negedge clk) begin
		logic nv;
		lst_item_t s;
		if (arst_n) begin
			nv = in_valid && !in_taken;
			if (!nv) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (pending_samples.size() != 0
						&& !(n_sent == PAUSE_AT && expected_rows.size() != 0)) begin
					s = pending_samples.pop_front();
					op_index <= s.idx;
					latency_us <= s.lat;
					nv = 1'b1;
					// idle bursts, none near the end
					if (pending_samples.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
						src_gap = $urandom_range(1, 3);
				end
			end
			in_valid <= nv;
		end
	end

	// Output ready: random short bursts, one long hold-off, none at the end
	always @(negedge clk) begin
		logic nr;
		nr = 1'b1;
		if (arst_n) begin
			if (!stall_done && n_checked >= STALL_AT) begin
				stall_done = 1'b1;
				stall_active = 1'b1;
				stall_left = STALL_CYCLES;
			end
			if (stall_active) begin
				nr = 1'b0;
				stall_left--;
				if (stall_left == 0)
					stall_active = 1'b0;
			end else if (sink_gap > 0) begin
				nr = 1'b0;
				sink_gap--;
			end else if (n_checked < total_items - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
				sink_gap = $urandom_range(0, 2);
				nr = 1'b0;
			end
		end
		out_ready <= nr;
	end

	// Monitor: predict on input accept, compare on output accept
	always @(posedge clk) begin
		row_report_t x;
		lst_item_t s;
		bit moved;
		moved = 1'b0;
		in_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				s.idx = op_index;
				s.lat = latency_us;
				expected_rows = {expected_rows, update_row(s)};
				n_sent++;
				in_taken = 1'b1;
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				if (expected_rows.size() == 0) begin
					$display("%0t: unexpected result for row %0d", $time, row_index);
					n_errors++;
				end else begin
					x = expected_rows.pop_front();
					n_checked++;
					if (x.sat)
						n_clipped++;
					if (row_index !== x.idx) begin
						$display("%0t: row_index expected %0d got %0d", $time, x.idx, row_index);
						n_errors++;
					end
					if (sample_count !== x.cnt) begin
						$display("%0t: sample_count expected %0d got %0d",
							$time, x.cnt, sample_count);
						n_errors++;
					end
					if (min_latency !== x.min_lat) begin
						$display("%0t: min_latency expected %0d got %0d",
							$time, x.min_lat, min_latency);
						n_errors++;
					end
					if (max_latency !== x.max_lat) begin
						$display("%0t: max_latency expected %0d got %0d",
							$time, x.max_lat, max_latency);
						n_errors++;
					end
					if (mean_latency !== x.mean) begin
						$display("%0t: mean_latency expected %h got %h",
							$time, x.mean, mean_latency);
						n_errors++;
					end
					if (variance !== x.var_q) begin
						$display("%0t: variance expected %h got %h", $time, x.var_q, variance);
						n_errors++;
					end
					if (total_samples !== x.total) begin
						$display("%0t: total_samples expected %0d got %0d",
							$time, x.total, total_samples);
						n_errors++;
					end
					if (saturated !== x.sat) begin
						$display("%0t: saturated expected %b got %b", $time, x.sat, saturated);
						n_errors++;
					end
				end
			end
			// watchdog on cycles with no item moving
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
				$display("Test completed with failures");
				$finish;
			end
		end
	end
endmodule

// File: latency_stats_table_top.f
src/lst_pkg.sv
src/lst_front.sv
src/lst_divider.sv
src/lst_back.sv
src/latency_stats_table_top.sv
tb/testbench.sv
